@@ design/tcw_pkg.sv @@
// Shared types and constants of the text console character writer.
package tcw_pkg;

  localparam int CMD_W    = 3;
  localparam int CHAR_W   = 8;
  localparam int SCOL_W   = 7;
  localparam int SROW_W   = 5;
  localparam int RIDX_W   = 11;
  localparam int POS_W    = 11;
  localparam int CELL_W   = 16;
  localparam int COLOUR_W = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 3'd0,
    CMD_SET   = 3'd1,
    CMD_CLEAR = 3'd2,
    CMD_BACK  = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  // register index is address bit 2 (registers on 4-byte steps)
  localparam logic REG_FG = 1'b0;
  localparam logic REG_BG = 1'b1;

  localparam logic [COLOUR_W-1:0] FG_RESET = 4'd7;
  localparam logic [COLOUR_W-1:0] BG_RESET = 4'd0;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

endpackage

@@ design/tcw_cmd_if.sv @@
// Command request channel of the text console character writer.
interface tcw_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::CMD_W-1:0]    cmd;
  logic [tcw_pkg::CHAR_W-1:0]   char_code;
  logic [tcw_pkg::SCOL_W-1:0]   set_col;
  logic [tcw_pkg::SROW_W-1:0]   set_row;
  logic [tcw_pkg::RIDX_W-1:0]   read_index;

  modport source (output valid, cmd, char_code, set_col, set_row, read_index, input ready);
  modport sink   (input valid, cmd, char_code, set_col, set_row, read_index, output ready);
endinterface

@@ design/tcw_res_if.sv @@
// Result request channel of the text console character writer.
interface tcw_res_if;
  logic                        valid;
  logic                        ready;
  logic [tcw_pkg::POS_W-1:0]   cursor_pos;
  logic [tcw_pkg::CELL_W-1:0]  cell_data;
  logic                        did_scroll;

  modport source (output valid, cursor_pos, cell_data, did_scroll, input ready);
  modport sink   (input valid, cursor_pos, cell_data, did_scroll, output ready);
endinterface

@@ design/text_console_char_writer.sv @@
// Text console character writer: screen store, cursor and command sequencer.
//
// A teletype-style text console. The screen is COLUMNS x ROWS cells of 16 bits
// (attribute high byte, character low byte) held in one synchronous RAM with a
// registered read; the cursor sits in registers. Each command request yields one
// result request carrying the linear cursor position after the command. A
// put-char that does not scroll, set-cursor, cursor-back, unknown commands and a
// read-cell past the end of the screen finish at the accepting edge; the next
// request can follow in the next cycle if no result is pending or out_ch.ready is
// high. A read-cell of a cell on the screen passes through S_READ (RAM read),
// then S_RESULT (result). Clear walks the RAM one cell a cycle. A put-char that
// runs off the last row scrolls: the RAM copy loop moves one cell a cycle, then
// the bottom row is blanked. After reset a clearing pass zeroes the screen; no
// command is taken meanwhile, while register writes are taken at all times.
// Colours are set through the APB port: fg_color at 0x0, bg_color at 0x4
// (address bit 2 selects the register).
module text_console_char_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                clk,
  input  logic                rst,
  tcw_cmd_if.sink             in_ch,
  tcw_res_if.source           out_ch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);     // RAM address
  localparam int CNT_W = $clog2(CELLS + 1); // sweep counter, holds CELLS
  localparam int CLW   = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  localparam logic [CLW-1:0]   LAST_COL  = CLW'(COLUMNS - 1);
  localparam logic [RW-1:0]    LAST_ROW  = RW'(ROWS - 1);
  localparam logic [CNT_W-1:0] CNT_END   = CNT_W'(CELLS);
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(CELLS - 1);
  localparam logic [CNT_W-1:0] CNT_COLS  = CNT_W'(COLUMNS);
  localparam logic [CNT_W-1:0] CNT_BOT   = CNT_W'(CELLS - COLUMNS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_COPY,
    S_BLANK,
    S_FILL,
    S_RESULT
  } state_t;

  state_t state;

  // screen RAM
  logic [tcw_pkg::CELL_W-1:0] screen [CELLS];
  logic [tcw_pkg::CELL_W-1:0] rd_data;

  // cursor and sweep
  logic [CLW-1:0]   cur_col, col_next;
  logic [RW-1:0]    cur_row, row_next;
  logic [AW-1:0]    pos;
  logic [CNT_W-1:0] cnt;
  logic             fill_zero;   // reset pass writes zero, clear writes blanks
  logic             cp_valid;    // copy loop: read data lands this cycle
  logic [AW-1:0]    cp_addr;

  // colours
  logic [tcw_pkg::COLOUR_W-1:0] fg_color, bg_color;

  // pending result of a multi-cycle command
  logic [tcw_pkg::CELL_W-1:0] res_cell;
  logic                       res_scroll;

  // output register
  logic                        out_valid;
  logic [tcw_pkg::POS_W-1:0]   out_pos;
  logic [tcw_pkg::CELL_W-1:0]  out_cell;
  logic                        out_scroll;

  logic                        out_free, accept;
  logic                        newline_req, scroll_req, read_hit;
  logic                        wr_en, rd_en;
  logic [AW-1:0]               wr_addr, rd_addr;
  logic [tcw_pkg::CELL_W-1:0]  wr_data, blank;
  logic [31:0]                 pos32, ridx32;
  logic [7:0]                  attr;

  assign attr     = {bg_color, fg_color};
  assign blank    = {attr, tcw_pkg::CH_SPACE};
  assign out_free = !out_valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE) && out_free;
  assign accept   = in_ch.ready && in_ch.valid;
  assign ridx32   = {21'd0, in_ch.read_index};

  assign out_ch.valid      = out_valid;
  assign out_ch.cursor_pos = out_pos;
  assign out_ch.cell_data  = out_cell;
  assign out_ch.did_scroll = out_scroll;

  assign pready = 1'b1;
  assign prdata = {28'd0, (paddr[2] == tcw_pkg::REG_BG) ? bg_color : fg_color};

  // linear cursor position of the cursor after this cycle
  assign pos32 = 32'(row_next) * 32'(COLUMNS) + 32'(col_next);

  always_comb begin
    col_next    = cur_col;
    row_next    = cur_row;
    newline_req = 1'b0;
    scroll_req  = 1'b0;
    read_hit    = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = cnt[AW-1:0];
    wr_data     = fill_zero ? '0 : blank;
    rd_en       = 1'b0;
    rd_addr     = cnt[AW-1:0];
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_ch.cmd)
            tcw_pkg::CMD_PUT: begin
              if (in_ch.char_code == tcw_pkg::CH_NEWLINE) begin
                newline_req = 1'b1;
              end else if (in_ch.char_code == tcw_pkg::CH_RETURN) begin
                col_next = '0;
              end else begin
                wr_en   = 1'b1;
                wr_addr = pos;
                wr_data = {attr, in_ch.char_code};
                if (cur_col == LAST_COL) begin
                  newline_req = 1'b1;
                end else begin
                  col_next = cur_col + 1'b1;
                end
              end
              if (newline_req) begin
                col_next = '0;
                if (cur_row == LAST_ROW) begin
                  scroll_req = 1'b1;  // row stays on the last line after scrolling
                end else begin
                  row_next = cur_row + 1'b1;
                end
              end
            end
            tcw_pkg::CMD_SET: begin
              col_next = (32'(in_ch.set_col) < 32'(COLUMNS)) ? CLW'(in_ch.set_col) : LAST_COL;
              row_next = (32'(in_ch.set_row) < 32'(ROWS)) ? RW'(in_ch.set_row) : LAST_ROW;
            end
            tcw_pkg::CMD_CLEAR: begin
              col_next = '0;
              row_next = '0;
            end
            tcw_pkg::CMD_BACK: begin
              if (cur_col != '0) begin
                col_next = cur_col - 1'b1;
              end else if (cur_row != '0) begin
                col_next = LAST_COL;
                row_next = cur_row - 1'b1;
              end
            end
            tcw_pkg::CMD_READ: begin
              if (ridx32 < 32'(CELLS)) begin
                read_hit = 1'b1;
                rd_en    = 1'b1;
                rd_addr  = ridx32[AW-1:0];
              end
            end
            default: ;
          endcase
        end
      end
      S_COPY: begin
        // read cell i+COLUMNS, write it to cell i in the next cycle
        if (cnt != CNT_END) begin
          rd_en   = 1'b1;
          rd_addr = cnt[AW-1:0];
        end
        if (cp_valid) begin
          wr_en   = 1'b1;
          wr_addr = cp_addr;
          wr_data = rd_data;
        end
      end
      S_BLANK: begin
        // new bottom row is always blanks in the current colours
        wr_en   = 1'b1;
        wr_data = blank;
      end
      S_FILL: begin
        wr_en = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      screen[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= screen[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      fill_zero <= 1'b1;
      cnt       <= '0;
      cp_valid  <= 1'b0;
      cur_col   <= '0;
      cur_row   <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
      fg_color  <= tcw_pkg::FG_RESET;
      bg_color  <= tcw_pkg::BG_RESET;
    end else begin
      cur_col  <= col_next;
      cur_row  <= row_next;
      pos      <= pos32[AW-1:0];
      cp_valid <= (state == S_COPY) && (cnt != CNT_END);
      cp_addr  <= AW'(cnt - CNT_COLS);

      if (out_ch.ready) begin
        out_valid <= 1'b0;
      end

      if (psel && penable && pwrite) begin
        if (paddr[2] == tcw_pkg::REG_BG) begin
          bg_color <= pwdata[3:0];
        end else begin
          fg_color <= pwdata[3:0];
        end
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_cell   <= '0;
            res_scroll <= scroll_req;
            if (scroll_req) begin
              cnt        <= CNT_COLS;
              state      <= S_COPY;
            end else if (in_ch.cmd == tcw_pkg::CMD_CLEAR) begin
              fill_zero <= 1'b0;
              cnt       <= '0;
              state     <= S_FILL;
            end else if (read_hit) begin
              state <= S_READ;
            end else begin
              out_valid  <= 1'b1;
              out_pos    <= pos32[tcw_pkg::POS_W-1:0];
              out_cell   <= '0;
              out_scroll <= 1'b0;
            end
          end
        end
        S_READ: begin
          res_cell <= rd_data;
          state    <= S_RESULT;
        end
        S_COPY: begin
          if (cnt == CNT_END) begin
            cnt   <= CNT_BOT;
            state <= S_BLANK;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_BLANK: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= S_RESULT;
          end
        end
        S_FILL: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= fill_zero ? S_IDLE : S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_pos    <= pos32[tcw_pkg::POS_W-1:0];
            out_cell   <= res_cell;
            out_scroll <= res_scroll;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
